FILE: rtl/simd_widening_three_different_alu_top_macros.svh
// ----------------------------------------------------------------------------
// simd_widening_three_different_alu_top_macros
// Assertion macros for the widening ALU.
// ----------------------------------------------------------------------------
`ifndef SIMD_WIDENING_THREE_DIFFERENT_ALU_TOP_MACROS_SVH
`define SIMD_WIDENING_THREE_DIFFERENT_ALU_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SWA_ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define SWA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SWA_ASSERT_IMPL(label, clk, rst, cond, msg)
`define SWA_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

FILE: rtl/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Types, opcodes and operation classes of the widening SIMD ALU.
// ----------------------------------------------------------------------------
package swa_pkg;
   typedef enum logic [4:0] {
      OP_SABAL = 5'd0, OP_SABDL = 5'd1, OP_SADDL = 5'd2, OP_SADDW = 5'd3,
      OP_SMLAL = 5'd4, OP_SMLSL = 5'd5, OP_SMULL = 5'd6, OP_SSUBW = 5'd7,
      OP_SSUBL = 5'd8, OP_UADDL = 5'd9, OP_UABAL = 5'd10, OP_UABDL = 5'd11,
      OP_UADDW = 5'd12, OP_UMLAL = 5'd13, OP_UMLSL = 5'd14, OP_UMULL = 5'd15,
      OP_USUBW = 5'd16, OP_USUBL = 5'd17, OP_PMULL = 5'd18, OP_SQDMULL = 5'd19
   } opcode_type;

   typedef enum logic [3:0] {
      K_ABD, K_ABA, K_ADDL, K_SUBL, K_ADDW, K_SUBW, K_MUL, K_MLA, K_MLS,
      K_PMUL, K_SQD
   } kind_type;

   localparam logic [1:0] SZ_B = 2'b00;
   localparam logic [1:0] SZ_H = 2'b01;
   localparam logic [1:0] SZ_S = 2'b10;
   localparam logic [1:0] SZ_D = 2'b11;

   typedef struct packed {
      logic [4:0]  opcode;
      logic        upper_half;
      logic [1:0]  size_code;
      logic [63:0] n_lo;
      logic [63:0] n_hi;
      logic [63:0] m_lo;
      logic [63:0] m_hi;
      logic [63:0] d_lo;
      logic [63:0] d_hi;
   } req_type;

   typedef struct packed {
      logic [63:0] result_lo;
      logic [63:0] result_hi;
      logic        reserved_encoding;
      logic        saturated;
   } rsp_type;

   function automatic kind_type kind_of(input logic [4:0] op);
      kind_type k;
      case (opcode_type'(op))
         OP_SABAL, OP_UABAL: k = K_ABA;
         OP_SABDL, OP_UABDL: k = K_ABD;
         OP_SADDL, OP_UADDL: k = K_ADDL;
         OP_SADDW, OP_UADDW: k = K_ADDW;
         OP_SMLAL, OP_UMLAL: k = K_MLA;
         OP_SMLSL, OP_UMLSL: k = K_MLS;
         OP_SMULL, OP_UMULL: k = K_MUL;
         OP_SSUBW, OP_USUBW: k = K_SUBW;
         OP_SSUBL, OP_USUBL: k = K_SUBL;
         OP_PMULL:           k = K_PMUL;
         OP_SQDMULL:         k = K_SQD;
         default:            k = K_ABD;
      endcase
      return k;
   endfunction
endpackage

FILE: rtl/swa_stream_if.sv
// ----------------------------------------------------------------------------
// swa_stream_if
// Valid/ready channel carrying one payload transaction.
// ----------------------------------------------------------------------------
interface swa_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/simd_widening_three_different_alu_top.sv
// ----------------------------------------------------------------------------
// simd_widening_three_different_alu_top
// Widening "three different" SIMD execution unit, four register stages.
// ----------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | opcode, upper_half, size_code, n/m/d lo and hi
// rsp     | out | result_lo, result_hi, reserved_encoding, saturated
//
// One transaction per cycle while the output is not stalled. Stage 1 decodes
// and picks the narrow halves, stage 2 forms the 32-bit element products
// and the 64x64 carry-less product, stage 3 forms the 8- and 16-bit element
// products, stage 4 applies the add/subtract/accumulate/difference/saturation
// step and the 8-bit carry-less step into the output.
// Reset (synchronous) clears the valid bits only.
// A stalled output holds every stage that is full; any bubble is filled.
`include "simd_widening_three_different_alu_top_macros.svh"
module simd_widening_three_different_alu_top (
   input logic clock,
   input logic reset,
   swa_stream_if.sink   req,
   swa_stream_if.source rsp
);
   // ---- pipeline control: stage i advances if it is empty or the next moves
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;
   assign en4 = !v4_ff || rsp.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // ---- stage 1: decode, pick narrow halves, compute sign extension info
   swa_pkg::req_type r1_ff;
   swa_pkg::kind_type k1_ff;
   logic sgn1_ff, rsv1_ff;
   logic [63:0] nn1_ff, nm1_ff;

   swa_pkg::kind_type k_in;
   logic rsv_in;
   always_comb begin
      k_in = swa_pkg::kind_of(req.payload.opcode);
      if (req.payload.opcode > swa_pkg::OP_SQDMULL) rsv_in = 1'b1;
      else if (k_in == swa_pkg::K_PMUL)
         rsv_in = (req.payload.size_code == swa_pkg::SZ_H) ||
                  (req.payload.size_code == swa_pkg::SZ_S);
      else if (k_in == swa_pkg::K_SQD)
         rsv_in = (req.payload.size_code == swa_pkg::SZ_B) ||
                  (req.payload.size_code == swa_pkg::SZ_D);
      else rsv_in = (req.payload.size_code == swa_pkg::SZ_D);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         r1_ff   <= req.payload;
         k1_ff   <= k_in;
         rsv1_ff <= rsv_in;
         sgn1_ff <= (req.payload.opcode <= swa_pkg::OP_SSUBL) ||
                    (req.payload.opcode == swa_pkg::OP_SQDMULL);
         nn1_ff  <= req.payload.upper_half ? req.payload.n_hi : req.payload.n_lo;
         nm1_ff  <= req.payload.upper_half ? req.payload.m_hi : req.payload.m_lo;
      end
   end

   // Sign- or zero-extend each narrow lane of a 64-bit half to 64 bits.
   // Lane i (of 64/e lanes) returned in slot i of an 8-slot array.
   function automatic logic [7:0][63:0] widen(input logic [63:0] v,
                                              input logic [1:0] sz,
                                              input logic s);
      logic [7:0][63:0] o;
      o = '0;
      case (sz)
         swa_pkg::SZ_B:
            for (int i = 0; i < 8; i++) o[i] = {{56{s & v[8*i+7]}}, v[8*i +: 8]};
         swa_pkg::SZ_H:
            for (int i = 0; i < 4; i++) o[i] = {{48{s & v[16*i+15]}}, v[16*i +: 16]};
         swa_pkg::SZ_S:
            for (int i = 0; i < 2; i++) o[i] = {{32{s & v[32*i+31]}}, v[32*i +: 32]};
         default: o[0] = v;
      endcase
      return o;
   endfunction

   // ---- stage 2: lanes and 32x32 partial products (64-bit lane products
   // only needed for 32-bit elements: low 32 bits x low 32 bits, signed or unsigned).
   logic [7:0][63:0] a2_ff, b2_ff;
   logic [1:0][63:0] pp2_ff;      // per 32-bit lane: full signed/unsigned product
   logic [127:0] clmul2_ff;
   swa_pkg::req_type r2_ff;
   swa_pkg::kind_type k2_ff;
   logic sgn2_ff, rsv2_ff;

   logic [7:0][63:0] a_w, b_w;
   logic [127:0] cl_w;
   always_comb begin
      a_w = widen(nn1_ff, r1_ff.size_code, sgn1_ff);
      b_w = widen(nm1_ff, r1_ff.size_code, sgn1_ff);
   end

   // Carry-less 64x64 of the selected halves; its full width is used for the 64-bit PMULL form.
   always_comb begin
      cl_w = '0;
      for (int i = 0; i < 64; i++)
         if (nm1_ff[i]) cl_w = cl_w ^ ({64'd0, nn1_ff} << i);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         r2_ff   <= r1_ff;
         k2_ff   <= k1_ff;
         sgn2_ff <= sgn1_ff;
         rsv2_ff <= rsv1_ff;
         a2_ff   <= a_w;
         b2_ff   <= b_w;
         clmul2_ff <= cl_w;
         for (int i = 0; i < 2; i++)
            pp2_ff[i] <= 64'($signed({sgn1_ff & a_w[i][31], a_w[i][31:0]}) *
                             $signed({sgn1_ff & b_w[i][31], b_w[i][31:0]}));
      end
   end

   // ---- stage 3: per-lane products at the element width
   logic [7:0][63:0] p3_ff, a3_ff, b3_ff;
   logic [127:0] clmul3_ff;
   swa_pkg::req_type r3_ff;
   swa_pkg::kind_type k3_ff;
   logic sgn3_ff, rsv3_ff;
   logic [7:0][63:0] p3_in;

   always_comb begin
      for (int i = 0; i < 8; i++)
         p3_in[i] = {32'd0, 32'($signed(a2_ff[i][16:0]) * $signed(b2_ff[i][16:0]))};
      if (r2_ff.size_code == swa_pkg::SZ_S) begin
         p3_in[0] = pp2_ff[0];
         p3_in[1] = pp2_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         r3_ff <= r2_ff; k3_ff <= k2_ff; sgn3_ff <= sgn2_ff; rsv3_ff <= rsv2_ff;
         a3_ff <= a2_ff; b3_ff <= b2_ff; clmul3_ff <= clmul2_ff;
         p3_ff <= p3_in;
      end
   end

   // ---- stage 4: lane operation and packing
   logic [127:0] res_w;
   logic sat_w;
   always_comb begin
      logic [63:0] a, b, p, dl, nl, r, mx, wmask, nmask, flip;
      logic [6:0]  w;
      int lanes;
      res_w = '0; sat_w = 1'b0;
      w = 7'd16 << r3_ff.size_code;
      lanes = 8 >> r3_ff.size_code;
      wmask = (w == 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
      nmask = (64'd1 << w[6:1]) - 64'd1;
      flip = sgn3_ff ? (64'd1 << (w[6:1] - 7'd1)) : 64'd0;
      for (int i = 0; i < 8; i++) begin
         a = a3_ff[i]; b = b3_ff[i]; p = p3_ff[i];
         dl = 64'({r3_ff.d_hi, r3_ff.d_lo} >> (i * w)) & wmask;
         nl = 64'({r3_ff.n_hi, r3_ff.n_lo} >> (i * w)) & wmask;
         mx = 64'd0 - (64'd1 << (w[6:1] - 7'd1)); // sign-extended narrow min
         case (k3_ff)
            swa_pkg::K_ABD, swa_pkg::K_ABA: begin
               // order the narrow elements; bias the sign bit for signed forms
               r = (((a & nmask) ^ flip) >= ((b & nmask) ^ flip)) ? a - b : b - a;
               if (k3_ff == swa_pkg::K_ABA) r = r + dl;
            end
            swa_pkg::K_ADDL: r = a + b;
            swa_pkg::K_SUBL: r = a - b;
            swa_pkg::K_ADDW: r = nl + b;
            swa_pkg::K_SUBW: r = nl - b;
            swa_pkg::K_MUL:  r = p;
            swa_pkg::K_MLA:  r = dl + p;
            swa_pkg::K_MLS:  r = dl - p;
            swa_pkg::K_PMUL: r = {48'd0, clmul3_ff[15:0]};
            default: begin
               if (a == mx && b == mx) begin
                  r = wmask >> 1;
                  if (i < lanes) sat_w = 1'b1;
               end else r = p << 1;
            end
         endcase
         if (k3_ff == swa_pkg::K_PMUL) begin
            // 8-bit lanes: carry-less product of the lane bytes
            r = '0;
            for (int j = 0; j < 8; j++) if (b[j]) r = r ^ ({56'd0, a[7:0]} << j);
         end
         if (i < lanes) res_w = res_w | (128'(r & wmask) << (i * w));
      end
      if (k3_ff == swa_pkg::K_PMUL && r3_ff.size_code == swa_pkg::SZ_D)
         res_w = clmul3_ff;
      if (rsv3_ff) begin
         res_w = '0; sat_w = 1'b0;
      end
   end

   swa_pkg::rsp_type o4_ff;
   always_ff @(posedge clock) begin
      if (en4) begin
         o4_ff.result_lo <= res_w[63:0];
         o4_ff.result_hi <= res_w[127:64];
         o4_ff.reserved_encoding <= rsv3_ff;
         o4_ff.saturated <= sat_w;
      end
   end
   assign rsp.valid = v4_ff;
   assign rsp.payload = o4_ff;

   // ---- checks
   `SWA_ASSERT_NEXT(a_hold, clock, reset, v4_ff && !rsp.ready,
                    v4_ff && $stable(o4_ff), "output changed under stall")
   `SWA_ASSERT_IMPL(a_rsv_zero, clock, reset,
                    !(v4_ff && o4_ff.reserved_encoding) ||
                    (o4_ff.result_lo == '0 && o4_ff.result_hi == '0 && !o4_ff.saturated),
                    "reserved result not zero")
   `SWA_ASSERT_NEXT(a_flow, clock, reset, v3_ff && en4, v4_ff, "stage 3 item lost")
endmodule
